// ===== rtl/mfo_pkg.sv =====
// shared constants and types for the mecanum forward odometry block
`timescale 1ns / 1ps

package mfo_pkg;

   // default parameter values
   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int FRAC_BITS_DEFAULT  = 16;

   // fixed field widths
   localparam int STAMP_BITS = 32;
   localparam int XY_WIDTH   = 41;
   localparam int YAW_WIDTH  = 48;

   // scale registers are unsigned q8.24
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 4;
   localparam int SCALE_FRAC     = 24;

   // multiplier operand width, one chunk of the wide operand per cycle
   localparam int CHUNK_BITS = 32;

   // lane numbering
   localparam int LANE_COUNT = 3;
   localparam int LANE_X     = 0;
   localparam int LANE_Y     = 1;
   localparam int LANE_YAW   = 2;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_DISTANCE_PER_PULSE  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_INV_CENTER_DISTANCE = CSR_INDEX_BITS'(1);

   // register reset values
   localparam logic [CSR_DATA_BITS-1:0] DISTANCE_PER_PULSE_RESET  = 32'd514719;
   localparam logic [CSR_DATA_BITS-1:0] INV_CENTER_DISTANCE_RESET = 32'd671089;

   // elapsed time when there is no usable previous stamp
   localparam logic [STAMP_BITS-1:0] DEFAULT_STEP_MS = 32'd10;

   // scale registers as seen by the lanes
   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] distance_per_pulse;
      logic [CSR_DATA_BITS-1:0] inv_center_distance;
   } csr_regs_type;

endpackage

// ===== rtl/mfo_lane.sv =====
// one scaling lane: magnitude, chunked multiply by one or two factors, shift, saturate
`timescale 1ns / 1ps

module mfo_lane #(
   parameter int COUNT_BITS  = mfo_pkg::COUNT_BITS_DEFAULT,
   parameter int FRAC_BITS   = mfo_pkg::FRAC_BITS_DEFAULT,
   parameter bit TWO_FACTORS = 1'b0,
   parameter int OUT_WIDTH   = mfo_pkg::XY_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [COUNT_BITS+1:0] sum,
   input  mfo_pkg::csr_regs_type       csr,
   input  logic                        ack,
   output logic                        done,
   output logic signed [OUT_WIDTH-1:0] result
);

   localparam int CH      = mfo_pkg::CHUNK_BITS;
   localparam int PPW     = 2 * CH;
   localparam int SUM_W   = COUNT_BITS + 2;
   localparam int N1      = (SUM_W + CH - 1) / CH;
   localparam int P1_W    = SUM_W + CH;
   localparam int N2      = (P1_W + CH - 1) / CH;
   localparam int NMAX    = TWO_FACTORS ? N2 : N1;
   localparam int AW      = NMAX * CH;
   localparam int PW      = TWO_FACTORS ? SUM_W + 2 * CH : P1_W;
   localparam int SHIFT   = TWO_FACTORS ? 2 + 2 * mfo_pkg::SCALE_FRAC - FRAC_BITS
                                        : 2 + mfo_pkg::SCALE_FRAC - FRAC_BITS;
   localparam int SW      = PW - SHIFT;
   localparam int CW      = ((SW > OUT_WIDTH) ? SW : OUT_WIDTH) + 1;
   localparam int CNT_W   = $clog2(NMAX + 1);
   localparam int LOAD1_SH = AW - N1 * CH;
   localparam int LOAD2_SH = (AW >= N2 * CH) ? AW - N2 * CH : 0;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_NEXT = 3'd3;
   localparam logic [2:0] ST_SAT  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   localparam logic [OUT_WIDTH-1:0] LIM_POS = {1'b0, {(OUT_WIDTH-1){1'b1}}};

   logic [2:0]             state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   pass2_ff, pass2_in;
   logic                   neg_ff, neg_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [AW-1:0]          a_ff, a_in;
   logic [PPW-1:0]         pp_ff, pp_in;
   logic [PW-1:0]          p_ff, p_in;
   logic [OUT_WIDTH-1:0]   mag_sat_ff, mag_sat_in;

   logic [SUM_W-1:0]       mag;
   logic [CH-1:0]          chunk;
   logic [CH-1:0]          factor;
   logic [CNT_W-1:0]       n_cur;
   logic [SW-1:0]          shifted;
   logic [OUT_WIDTH-1:0]   lim;

   // operand selection
   assign mag     = sum_ff[SUM_W-1] ? (~sum_ff + SUM_W'(1)) : sum_ff;
   assign chunk   = a_ff[AW-1 -: CH];
   assign factor  = pass2_ff ? csr.inv_center_distance : csr.distance_per_pulse;
   assign n_cur   = pass2_ff ? CNT_W'(N2) : CNT_W'(N1);
   assign shifted = SW'(p_ff >> SHIFT);
   assign lim     = LIM_POS + OUT_WIDTH'(neg_ff);

   // lane sequencer
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      pass2_in   = pass2_ff;
      neg_in     = neg_ff;
      sum_in     = sum_ff;
      a_in       = a_ff;
      pp_in      = pp_ff;
      p_in       = p_ff;
      mag_sat_in = mag_sat_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               sum_in   = sum;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            neg_in   = sum_ff[SUM_W-1];
            a_in     = AW'(mag) << LOAD1_SH;
            cnt_in   = '0;
            pass2_in = 1'b0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // top chunk first: accumulator shifts up one chunk per product
            if (cnt_ff < n_cur) begin
               pp_in = PPW'(chunk) * PPW'(factor);
               a_in  = a_ff << CH;
            end
            if (cnt_ff == '0) begin
               p_in = '0;
            end else begin
               p_in = (p_ff << CH) + PW'(pp_ff);
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == n_cur) begin
               cnt_in = '0;
               if (TWO_FACTORS && !pass2_ff) begin
                  state_in = ST_NEXT;
               end else begin
                  state_in = ST_SAT;
               end
            end
         end
         ST_NEXT: begin
            a_in     = AW'(p_ff) << LOAD2_SH;
            pass2_in = 1'b1;
            cnt_in   = '0;
            state_in = ST_MUL;
         end
         ST_SAT: begin
            if (CW'(shifted) > CW'(lim)) begin
               mag_sat_in = lim;
            end else begin
               mag_sat_in = OUT_WIDTH'(shifted);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         pass2_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pass2_ff <= pass2_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      neg_ff     <= neg_in;
      sum_ff     <= sum_in;
      a_ff       <= a_in;
      pp_ff      <= pp_in;
      p_ff       <= p_in;
      mag_sat_ff <= mag_sat_in;
   end

   // restore the sign
   assign done   = (state_ff == ST_DONE);
   assign result = neg_ff ? signed'(~mag_sat_ff + OUT_WIDTH'(1)) : signed'(mag_sat_ff);

endmodule

// ===== rtl/mfo_merge.sv =====
// merging stage: gathers the lane results and the elapsed time into the output register
`timescale 1ns / 1ps

module mfo_merge (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic [mfo_pkg::LANE_COUNT-1:0]           lane_done,
   input  logic signed [mfo_pkg::XY_WIDTH-1:0]      lane_x,
   input  logic signed [mfo_pkg::XY_WIDTH-1:0]      lane_y,
   input  logic signed [mfo_pkg::YAW_WIDTH-1:0]     lane_yaw,
   input  logic [mfo_pkg::STAMP_BITS-1:0]           step,
   output logic                                     lane_ack,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [mfo_pkg::XY_WIDTH-1:0]      rsp_delta_x,
   output logic signed [mfo_pkg::XY_WIDTH-1:0]      rsp_delta_y,
   output logic signed [mfo_pkg::YAW_WIDTH-1:0]     rsp_delta_yaw,
   output logic [mfo_pkg::STAMP_BITS-1:0]           rsp_step_ms
);

   logic                                 valid_ff, valid_in;
   logic                                 load;
   logic signed [mfo_pkg::XY_WIDTH-1:0]  x_ff;
   logic signed [mfo_pkg::XY_WIDTH-1:0]  y_ff;
   logic signed [mfo_pkg::YAW_WIDTH-1:0] yaw_ff;
   logic [mfo_pkg::STAMP_BITS-1:0]       step_ff;

   // take the lanes once all are done and the output slot is free or draining
   assign load     = (&lane_done) & (~valid_ff | ~rsp_stall);
   assign valid_in = load | (valid_ff & rsp_stall);
   assign lane_ack = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (load) begin
         x_ff    <= lane_x;
         y_ff    <= lane_y;
         yaw_ff  <= lane_yaw;
         step_ff <= step;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_delta_x   = x_ff;
   assign rsp_delta_y   = y_ff;
   assign rsp_delta_yaw = yaw_ff;
   assign rsp_step_ms   = step_ff;

endmodule

// ===== rtl/mecanum_forward_odometry.sv =====
// top level of the mecanum forward odometry block
`timescale 1ns / 1ps

// Takes four signed wheel encoder deltas and a millisecond stamp per transaction and
// returns one pose delta: delta_x and delta_y in cm and delta_yaw in radians, all
// signed Q.FRAC_BITS, truncated toward zero and saturated, plus step_ms, the time
// since the previous stamp (10 ms when the previous stamp is zero or not older).
// Three lanes (x, y, yaw) work side by side, each running its wide product through
// one 32x32 multiplier a 32-bit chunk per cycle; the yaw lane makes two passes
// (distance_per_pulse, then inv_center_distance) and sets the pace. From acceptance
// a transaction goes through load, multiply, switch of factor, multiply again,
// saturate and hand-off before the next one can be accepted; a finished result
// waits in the output register while the next transaction is taken.
// Scale registers sit at index 0 (distance_per_pulse) and 1 (inv_center_distance),
// are always ready, and must only be written while no transaction is in flight.
module mecanum_forward_odometry #(
   parameter int COUNT_BITS = mfo_pkg::COUNT_BITS_DEFAULT,
   parameter int FRAC_BITS  = mfo_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [COUNT_BITS-1:0]           req_count_front_left,
   input  logic signed [COUNT_BITS-1:0]           req_count_front_right,
   input  logic signed [COUNT_BITS-1:0]           req_count_rear_left,
   input  logic signed [COUNT_BITS-1:0]           req_count_rear_right,
   input  logic [mfo_pkg::STAMP_BITS-1:0]         req_stamp_ms,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [mfo_pkg::XY_WIDTH-1:0]    rsp_delta_x,
   output logic signed [mfo_pkg::XY_WIDTH-1:0]    rsp_delta_y,
   output logic signed [mfo_pkg::YAW_WIDTH-1:0]   rsp_delta_yaw,
   output logic [mfo_pkg::STAMP_BITS-1:0]         rsp_step_ms,
   // register write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [mfo_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [mfo_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam int SUM_W = COUNT_BITS + 2;

   mfo_pkg::csr_regs_type                csr_ff, csr_in;
   logic                                 busy_ff, busy_in;
   logic [mfo_pkg::STAMP_BITS-1:0]       prev_stamp_ff, prev_stamp_in;
   logic [mfo_pkg::STAMP_BITS-1:0]       step_ff, step_in;

   logic                                 accept;
   logic                                 lane_ack;
   logic [mfo_pkg::LANE_COUNT-1:0]       lane_done;
   logic signed [SUM_W-1:0]              fl, fr, rl, rr;
   logic signed [SUM_W-1:0]              sum_x, sum_y, sum_w;
   logic signed [mfo_pkg::XY_WIDTH-1:0]  lane_x, lane_y;
   logic signed [mfo_pkg::YAW_WIDTH-1:0] lane_yaw;

   // one transaction in flight at a time
   assign req_stall = busy_ff;
   assign accept    = req_valid & ~busy_ff;
   assign busy_in   = accept | (busy_ff & ~lane_ack);

   // register writes
   assign csr_ready = 1'b1;
   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         case (csr_index)
            mfo_pkg::REG_DISTANCE_PER_PULSE:  csr_in.distance_per_pulse  = csr_wdata;
            mfo_pkg::REG_INV_CENTER_DISTANCE: csr_in.inv_center_distance = csr_wdata;
            default: begin
               csr_in = csr_ff;
            end
         endcase
      end
   end

   // elapsed time and stamp update
   always_comb begin
      prev_stamp_in = prev_stamp_ff;
      step_in       = step_ff;
      if (accept) begin
         prev_stamp_in = req_stamp_ms;
         if (prev_stamp_ff != '0 && req_stamp_ms > prev_stamp_ff) begin
            step_in = req_stamp_ms - prev_stamp_ff;
         end else begin
            step_in = mfo_pkg::DEFAULT_STEP_MS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.distance_per_pulse  <= mfo_pkg::DISTANCE_PER_PULSE_RESET;
         csr_ff.inv_center_distance <= mfo_pkg::INV_CENTER_DISTANCE_RESET;
         busy_ff                    <= 1'b0;
         prev_stamp_ff              <= '0;
      end else begin
         csr_ff        <= csr_in;
         busy_ff       <= busy_in;
         prev_stamp_ff <= prev_stamp_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
   end

   // mecanum sums
   assign fl    = SUM_W'(req_count_front_left);
   assign fr    = SUM_W'(req_count_front_right);
   assign rl    = SUM_W'(req_count_rear_left);
   assign rr    = SUM_W'(req_count_rear_right);
   assign sum_x = fl + fr + rl + rr;
   assign sum_y = fr + rl - fl - rr;
   assign sum_w = fr + rr - fl - rl;

   // scaling lanes
   mfo_lane #(
      .COUNT_BITS (COUNT_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .TWO_FACTORS(1'b0),
      .OUT_WIDTH  (mfo_pkg::XY_WIDTH)
   ) u_lane_x (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .sum   (sum_x),
      .csr   (csr_ff),
      .ack   (lane_ack),
      .done  (lane_done[mfo_pkg::LANE_X]),
      .result(lane_x)
   );

   mfo_lane #(
      .COUNT_BITS (COUNT_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .TWO_FACTORS(1'b0),
      .OUT_WIDTH  (mfo_pkg::XY_WIDTH)
   ) u_lane_y (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .sum   (sum_y),
      .csr   (csr_ff),
      .ack   (lane_ack),
      .done  (lane_done[mfo_pkg::LANE_Y]),
      .result(lane_y)
   );

   mfo_lane #(
      .COUNT_BITS (COUNT_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .TWO_FACTORS(1'b1),
      .OUT_WIDTH  (mfo_pkg::YAW_WIDTH)
   ) u_lane_yaw (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .sum   (sum_w),
      .csr   (csr_ff),
      .ack   (lane_ack),
      .done  (lane_done[mfo_pkg::LANE_YAW]),
      .result(lane_yaw)
   );

   // merge and output register
   mfo_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .lane_done    (lane_done),
      .lane_x       (lane_x),
      .lane_y       (lane_y),
      .lane_yaw     (lane_yaw),
      .step         (step_ff),
      .lane_ack     (lane_ack),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_delta_x  (rsp_delta_x),
      .rsp_delta_y  (rsp_delta_y),
      .rsp_delta_yaw(rsp_delta_yaw),
      .rsp_step_ms  (rsp_step_ms)
   );

endmodule
